[src/gda_pkg.sv]
// Package for the goal distance accumulator: widths, register indexes,
// sequencer states and the shift-add and restoring-root step functions.
// No dependencies.
`default_nettype none

package gda_pkg;

  localparam int MAX_BODIES   = 64;
  localparam int COUNT_W      = $clog2(MAX_BODIES + 1);
  localparam int BODY_IDX_W   = $clog2(MAX_BODIES);

  localparam int COORD_W      = 32;
  localparam int MAG_W        = COORD_W + 1;   // |dx|, |dy| stay below 2^32
  localparam int PROD_W       = 2 * MAG_W;     // 66-bit products and radicands
  localparam int ROOT_W       = MAG_W;         // root of a 66-bit value
  localparam int REM_W        = ROOT_W + 2;    // remainder stays below 2*root+1
  localparam int TERM_W       = ROOT_W + 1;

  localparam int SUM_W        = 40;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam int IN_TDATA_W   = 6 * COORD_W;
  localparam int OUT_TDATA_W  = 48;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = SUM_W;

  localparam logic [CFG_IDX_W-1:0] REG_BODY_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONLY_END      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_THRESHOLD = 2'd2;

  // Both the multiplier and the root unit take one step per bit or bit pair.
  localparam int STEPS        = MAG_W;
  localparam int STEP_CNT_W   = $clog2(STEPS);
  localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(STEPS - 1);

  // The only-end mode counts the body this many places before the end.
  localparam logic [COUNT_W-1:0] END_OFFSET = COUNT_W'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMBINE,
    ST_ROOT,
    ST_ACCUM
  } state_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } root_state_t;

  // One shift-add step: the multiplier sits in the low half and leaves one
  // bit per step while partial sums enter from the top.
  function automatic logic [PROD_W-1:0] mul_step(input logic [PROD_W-1:0] prod,
                                                 input logic [MAG_W-1:0]  mcand);
    logic [MAG_W:0] psum;
    psum = {1'b0, prod[PROD_W-1:MAG_W]} + (prod[0] ? {1'b0, mcand} : {(MAG_W+1){1'b0}});
    return {psum, prod[MAG_W-1:1]};
  endfunction

  // One restoring square root step on the next bit pair of the radicand.
  function automatic root_state_t root_step(input root_state_t st,
                                            input logic [1:0]  pair);
    root_state_t    res;
    logic [REM_W+1:0] shifted;
    logic [REM_W+1:0] trial;
    shifted = {st.rem, pair};
    trial   = {2'b00, st.root, 2'b01};
    if (shifted >= trial) begin
      res.rem  = REM_W'(shifted - trial);
      res.root = {st.root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = shifted[REM_W-1:0];
      res.root = {st.root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[src/goal_distance_accumulator_core.sv]
// Top level of the goal distance accumulator: stream in, stream out, config
// write port, bit-serial multipliers and restoring square root units.
// Depends on gda_pkg.
`default_nettype none

// How to use this block
// The slave stream carries one body per transfer: goal x/y, current x/y and
// planar velocity x/y, all signed Q16.16. The block forms dx and dy, the
// distance sqrt(dx*dx+dy*dy), and adds sqrt(|dot|) when the dot product of
// the offset with the velocity is zero or negative. Terms are summed over the
// bodies of one state (body_count bodies; in only-end mode only the body at
// index body_count-3 counts). After the last body of a state one transfer on
// the master stream carries the saturated Q24.16 sum and the flag that the
// sum is strictly below goal_threshold.
// Each body runs from its transfer through the multiply steps of four
// shift-add multipliers (one multiplier bit each per cycle), one combine
// step, the steps of two restoring root units (one radicand bit pair each
// per cycle) and one accumulate step, back to the idle state in which
// s_tready is high again. A finished result waits in the output register
// while the next body is accepted; if the receiver still holds off when the
// following result is ready, the block waits in its accumulate step. Reset
// clears the sum, the body index and the registers to their defaults (one
// body per state, only-end off, threshold zero). Writing body_count starts
// a new state; the user must write configuration only while idle, and the
// block itself does not enforce this.
module goal_distance_accumulator_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // s_tdata fields from bit 0: target_x, target_y, pos_x, pos_y, vel_x, vel_y
  input  wire logic [gda_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  wire logic                                s_tvalid,
  output      logic                                s_tready,
  // m_tdata fields from bit 0: distance_sum[39:0], satisfied, zero padding
  output      logic [gda_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output      logic                                m_tvalid,
  input  wire logic                                m_tready,
  input  wire logic                                cfg_we,
  input  wire logic [gda_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gda_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int MW = gda_pkg::MAG_W;
  localparam int PW = gda_pkg::PROD_W;
  localparam int CW = gda_pkg::COORD_W;
  localparam int SW = gda_pkg::SUM_W;
  localparam int KW = gda_pkg::COUNT_W;
  localparam int NW = gda_pkg::STEP_CNT_W;

  gda_pkg::state_t state, state_next;

  // Configuration.
  logic [KW-1:0] body_count;
  logic          only_end;
  logic [SW-1:0] goal_threshold;

  // Accumulation state.
  logic [SW-1:0]                   running_sum;
  logic [gda_pkg::BODY_IDX_W-1:0]  body_index;

  // Datapath registers.
  logic [NW-1:0]  step_cnt;
  logic [MW-1:0]  mag_dx, mag_dy;
  logic           neg1_pre, neg2_pre;
  logic [PW-1:0]  prod_sx, prod_sy, prod_p1, prod_p2;
  logic [PW-1:0]  rad_a, rad_b;
  logic           positive;
  gda_pkg::root_state_t root_a, root_b;

  // Output register.
  logic [SW-1:0]  out_sum;
  logic           out_sat;

  // Input fields.
  logic signed [CW-1:0] target_x, target_y, pos_x, pos_y, vel_x, vel_y;
  logic        [CW:0]   dx, dy;

  assign target_x = s_tdata[0*CW +: CW];
  assign target_y = s_tdata[1*CW +: CW];
  assign pos_x    = s_tdata[2*CW +: CW];
  assign pos_y    = s_tdata[3*CW +: CW];
  assign vel_x    = s_tdata[4*CW +: CW];
  assign vel_y    = s_tdata[5*CW +: CW];

  assign dx = {target_x[CW-1], target_x} - {pos_x[CW-1], pos_x};
  assign dy = {target_y[CW-1], target_y} - {pos_y[CW-1], pos_y};

  // Combine step: distance radicand and the dot product in sign-magnitude.
  logic [63:0] p1, p2, dmag;
  logic        n1, n2, positive_c;
  logic [PW-1:0] rad_sum;

  assign p1 = prod_p1[63:0];
  assign p2 = prod_p2[63:0];
  assign n1 = neg1_pre && (p1 != 64'd0);
  assign n2 = neg2_pre && (p2 != 64'd0);
  assign rad_sum = prod_sx + prod_sy;

  always_comb begin
    if (n1 == n2) begin
      dmag       = p1 + p2;
      positive_c = !n1 && (dmag != 64'd0);
    end else if (p1 >= p2) begin
      dmag       = p1 - p2;
      positive_c = !n1 && (dmag != 64'd0);
    end else begin
      dmag       = p2 - p1;
      positive_c = !n2;
    end
  end

  // Accumulate step: body counting rules and the saturating sum.
  logic [KW-1:0]               count_eff, idx, idx_inc;
  logic                        counted, last_body, accum_done;
  logic [gda_pkg::TERM_W-1:0]  term;
  logic [SW:0]                 sum_wide;
  logic [SW-1:0]               sum_sat, sum_new;

  always_comb begin
    if (body_count == '0) begin
      count_eff = KW'(1);
    end else if (body_count > KW'(gda_pkg::MAX_BODIES)) begin
      count_eff = KW'(gda_pkg::MAX_BODIES);
    end else begin
      count_eff = body_count;
    end
    idx = ({1'b0, body_index} >= count_eff) ? '0 : {1'b0, body_index};
    idx_inc = idx + KW'(1);
    if (only_end) begin
      counted = (count_eff >= gda_pkg::END_OFFSET) &&
                (idx == count_eff - gda_pkg::END_OFFSET);
    end else begin
      counted = 1'b1;
    end
    last_body = idx_inc >= count_eff;
    term = {1'b0, root_a.root} + (positive ? '0 : {1'b0, root_b.root});
    sum_wide = {1'b0, running_sum} + (SW+1)'(term);
    sum_sat  = sum_wide[SW] ? gda_pkg::SUM_MAX : sum_wide[SW-1:0];
    sum_new  = counted ? sum_sat : running_sum;
  end

  // The accumulate step finishes when it can hand its result on.
  assign accum_done = (state == gda_pkg::ST_ACCUM) && (state_next == gda_pkg::ST_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gda_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      gda_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = gda_pkg::ST_MUL;
      end
      gda_pkg::ST_MUL: begin
        if (step_cnt == gda_pkg::STEP_LAST) state_next = gda_pkg::ST_COMBINE;
      end
      gda_pkg::ST_COMBINE: begin
        state_next = gda_pkg::ST_ROOT;
      end
      gda_pkg::ST_ROOT: begin
        if (step_cnt == gda_pkg::STEP_LAST) state_next = gda_pkg::ST_ACCUM;
      end
      gda_pkg::ST_ACCUM: begin
        if (!last_body || !m_tvalid || m_tready) state_next = gda_pkg::ST_IDLE;
      end
      default: begin
        state_next = gda_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath: no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      gda_pkg::ST_IDLE: begin
        step_cnt <= '0;
        mag_dx   <= dx[CW] ? MW'(-dx) : dx;
        mag_dy   <= dy[CW] ? MW'(-dy) : dy;
        neg1_pre <= dx[CW] != vel_x[CW-1];
        neg2_pre <= dy[CW] != vel_y[CW-1];
        prod_sx  <= {{MW{1'b0}}, (dx[CW] ? MW'(-dx) : dx)};
        prod_sy  <= {{MW{1'b0}}, (dy[CW] ? MW'(-dy) : dy)};
        prod_p1  <= {{(MW+1){1'b0}}, (vel_x[CW-1] ? -vel_x : vel_x)};
        prod_p2  <= {{(MW+1){1'b0}}, (vel_y[CW-1] ? -vel_y : vel_y)};
      end
      gda_pkg::ST_MUL: begin
        step_cnt <= (step_cnt == gda_pkg::STEP_LAST) ? '0 : step_cnt + NW'(1);
        prod_sx  <= gda_pkg::mul_step(prod_sx, mag_dx);
        prod_sy  <= gda_pkg::mul_step(prod_sy, mag_dy);
        prod_p1  <= gda_pkg::mul_step(prod_p1, mag_dx);
        prod_p2  <= gda_pkg::mul_step(prod_p2, mag_dy);
      end
      gda_pkg::ST_COMBINE: begin
        rad_a    <= rad_sum;
        rad_b    <= {2'b00, dmag};
        positive <= positive_c;
        root_a   <= '0;
        root_b   <= '0;
      end
      gda_pkg::ST_ROOT: begin
        step_cnt <= (step_cnt == gda_pkg::STEP_LAST) ? '0 : step_cnt + NW'(1);
        root_a   <= gda_pkg::root_step(root_a, rad_a[PW-1:PW-2]);
        root_b   <= gda_pkg::root_step(root_b, rad_b[PW-1:PW-2]);
        rad_a    <= {rad_a[PW-3:0], 2'b00};
        rad_b    <= {rad_b[PW-3:0], 2'b00};
      end
      default: begin
      end
    endcase
  end

  // Configuration, accumulation state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      body_count     <= KW'(1);
      only_end       <= 1'b0;
      goal_threshold <= '0;
      running_sum    <= '0;
      body_index     <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // A new result may replace one that leaves in the same cycle.
      if (accum_done && last_body) begin
        out_sum  <= sum_new;
        out_sat  <= sum_new < goal_threshold;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we && cfg_index == gda_pkg::REG_BODY_COUNT) begin
        running_sum <= '0;
        body_index  <= '0;
      end else if (accum_done) begin
        if (last_body) begin
          running_sum <= '0;
          body_index  <= '0;
        end else begin
          running_sum <= sum_new;
          body_index  <= idx_inc[gda_pkg::BODY_IDX_W-1:0];
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          gda_pkg::REG_BODY_COUNT: begin
            body_count <= cfg_data[KW-1:0];
          end
          gda_pkg::REG_ONLY_END: begin
            only_end <= cfg_data[0];
          end
          gda_pkg::REG_GOAL_THRESHOLD: begin
            goal_threshold <= cfg_data[SW-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign m_tdata = {{(gda_pkg::OUT_TDATA_W-SW-1){1'b0}}, out_sat, out_sum};

endmodule

`default_nettype wire

[src/gda_checker.sv]
// Port-level checks for the goal distance accumulator, bound to the top level.
// Depends on gda_pkg and goal_distance_accumulator_core.
`default_nettype none

module gda_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic [gda_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready
);

  // After reset the block is ready for a body and holds no result.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (s_tready && !m_tvalid))
    else $error("block not idle after reset");

  // A body transfer makes the block busy in the next cycle.
  a_busy_after_input: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("block ready again right after a body transfer");

  // A new result only appears from the accumulate step, when input is held off.
  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared while the block was idle");

  // A stalled result keeps its value.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed or was dropped");

endmodule

bind goal_distance_accumulator_core gda_checker u_gda_checker (.*);

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for goal_distance_accumulator_core: a short directed list of
// bodies and register writes, then randomized phases, all scored against a local model.
// Depends on gda_pkg and the core RTL; reads no files.
module tb_top;

  localparam int CFG_IDX_W   = gda_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = gda_pkg::CFG_DATA_W;
  localparam int SUM_W       = gda_pkg::SUM_W;
  localparam int IN_TDATA_W  = gda_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = gda_pkg::OUT_TDATA_W;
  localparam int COUNT_W     = gda_pkg::COUNT_W;
  localparam int MAX_BODIES  = gda_pkg::MAX_BODIES;
  localparam logic [SUM_W-1:0] SUM_MAX = gda_pkg::SUM_MAX;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 5;
  // This covers a body that is still being worked on inside the core when
  // the last pending sum has already left.
  localparam int SETTLE_CYCLES = 80;
  localparam int TARGET_BODIES = 1500;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_REPORTS   = 10;

  // Index 3 is not a register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // Laid out so that target_x lands in the lowest bits of s_tdata.
  typedef struct packed {
    logic [31:0] vel_y;
    logic [31:0] vel_x;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
    logic [31:0] target_y;
    logic [31:0] target_x;
  } body_t;

  // Matches m_tdata[40:0]: the sum from bit 0, the flag above it.
  typedef struct packed {
    logic             satisfied;
    logic [SUM_W-1:0] distance_sum;
  } result_t;

  typedef enum bit {ROW_WRITE, ROW_BODY} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
    body_t                 body;
    bit                    has_known;
    result_t               known;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Local copy of the register file and of the accumulation state.
  logic [COUNT_W-1:0] model_count = COUNT_W'(1);
  logic               model_only_end = 1'b0;
  logic [SUM_W-1:0]   model_threshold = '0;
  logic [SUM_W-1:0]   model_sum = '0;
  int                 model_pos = 0;

  // Sums predicted for bodies already transferred, oldest first.
  result_t   pending_sums[$];
  stim_row_t directed_rows[$];

  int mismatches  = 0;
  int bodies_sent = 0;
  int sums_seen   = 0;
  int sums_under  = 0;
  int writes_done = 0;
  int cycle_count = 0;

  // When set, the matching side runs without idle cycles for the phase.
  bit in_rush  = 1'b0;
  bit out_rush = 1'b0;

  goal_distance_accumulator_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost sum ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d sums pending", cycle_count,
               pending_sums.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Integer square root found one result bit at a time, highest first: a bit
  // stays set when the square of the candidate still fits under the radicand.
  function automatic logic [32:0] isqrt_floor(input logic [65:0] radicand);
    logic [32:0] root;
    logic [67:0] trial;
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      trial = {35'd0, root | (33'd1 << b)};
      if (trial * trial <= {2'b00, radicand}) root = root | (33'd1 << b);
    end
    return root;
  endfunction

  // Cost of one body in Q16.16. The offset and the velocity are widened so that
  // the squares and the dot product are exact; the roots truncate.
  function automatic logic [34:0] distance_term(input body_t b);
    logic signed [32:0] dx, dy, vx, vy;
    logic signed [67:0] dist_sq, dot;
    logic [67:0]        dot_mag;
    logic [34:0]        term;
    dx = {b.target_x[31], b.target_x} - {b.pos_x[31], b.pos_x};
    dy = {b.target_y[31], b.target_y} - {b.pos_y[31], b.pos_y};
    vx = {b.vel_x[31], b.vel_x};
    vy = {b.vel_y[31], b.vel_y};
    dist_sq = dx * dx + dy * dy;
    dot     = dx * vx + dy * vy;
    term = 35'(isqrt_floor(dist_sq[65:0]));
    // A body heading toward its goal (dot above zero) adds nothing more; one
    // that stands still, moves sideways or moves away pays sqrt(|dot|).
    if (dot <= 0) begin
      dot_mag = -dot;
      term = term + 35'(isqrt_floor(dot_mag[65:0]));
    end
    return term;
  endfunction

  // Bodies per state as the core sees it: zero means one, the top is clamped.
  function automatic int effective_span(input logic [COUNT_W-1:0] count);
    if (count == 0) return 1;
    if (count > MAX_BODIES) return MAX_BODIES;
    return int'(count);
  endfunction

  // Moves the local state by one transferred body and tells whether the body
  // closes a state, and with which sum.
  task automatic advance_model(input body_t b, output bit emits, output result_t outcome);
    int          span;
    logic [40:0] total;
    span = effective_span(model_count);
    if (model_pos >= span) model_pos = 0;
    // In only-end mode only the body three places before the end counts, so
    // states of one or two bodies always sum to zero.
    if (!model_only_end || (span >= 3 && model_pos == span - 3)) begin
      total = 41'(model_sum) + 41'(distance_term(b));
      model_sum = (total > 41'(SUM_MAX)) ? SUM_MAX : total[SUM_W-1:0];
    end
    emits = (model_pos + 1 >= span);
    outcome = '0;
    if (emits) begin
      outcome.distance_sum = model_sum;
      outcome.satisfied    = model_sum < model_threshold;
      model_sum = '0;
      model_pos = 0;
    end else begin
      model_pos++;
    end
  endtask

  // One register write; a body_count write starts a fresh state. The final
  // clock wait keeps cfg_we from being lowered and raised in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      gda_pkg::REG_BODY_COUNT: begin
        model_count = value[COUNT_W-1:0];
        model_sum   = '0;
        model_pos   = 0;
      end
      gda_pkg::REG_ONLY_END:       model_only_end = value[0];
      gda_pkg::REG_GOAL_THRESHOLD: model_threshold = value;
      default: ;
    endcase
    writes_done++;
    @(posedge clk);
  endtask

  // Offers one body on the slave stream. Entered and left at a rising edge;
  // the valid stays high into the next body when no gap is drawn. s_tready is
  // looked at on the falling edge, where nothing is changing.
  task automatic send_body(input body_t b, input bit has_known, input result_t known);
    int      gap;
    bit      emits;
    result_t outcome;
    result_t queued;
    gap = in_rush ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= b;
    s_tvalid <= 1'b1;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    bodies_sent++;
    advance_model(b, emits, outcome);
    // Rows with a hand-written sum are scored against that value instead.
    if (emits) begin
      queued = has_known ? known : outcome;
      pending_sums = {pending_sums, queued};
    end
  endtask

  // Appends one row to the directed list.
  task automatic add_row(input stim_row_t r);
    directed_rows = {directed_rows, r};
  endtask

  // Holds the sender until every pending sum has been seen, then lets the
  // core finish any body that closes no state.
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string field, input logic [SUM_W-1:0] want,
                               input logic [SUM_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("ERROR at %0t: %s expected %h, got %h", $time, field, want, got);
  endtask

  task automatic score_sum(input result_t got);
    result_t want;
    sums_seen++;
    if (got.satisfied) sums_under++;
    if (pending_sums.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("ERROR at %0t: sum transfer with nothing pending (sum %h, flag %0b)",
                 $time, got.distance_sum, got.satisfied);
    end else begin
      want = pending_sums.pop_front();
      if (got.distance_sum !== want.distance_sum)
        flag_mismatch("distance_sum", want.distance_sum, got.distance_sum);
      if (got.satisfied !== want.satisfied)
        flag_mismatch("satisfied", SUM_W'(want.satisfied), SUM_W'(got.satisfied));
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[CFG_DATA_W-1:0];
  endfunction

  // Mostly short states, now and then a count of zero, the largest count, or
  // a value above it that the core must clamp.
  function automatic logic [COUNT_W-1:0] pick_count();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel <= 11) return COUNT_W'($urandom_range(1, 4));
    else if (sel <= 16) return COUNT_W'($urandom_range(5, 16));
    else if (sel == 17) return '0;
    else if (sel == 18) return COUNT_W'(MAX_BODIES);
    else return COUNT_W'($urandom_range(MAX_BODIES + 1, 127));
  endfunction

  // Thresholds spread over every magnitude, so that both flag values show up
  // for sums of small and of large bodies.
  function automatic logic [SUM_W-1:0] pick_threshold();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return SUM_MAX;
      default: return rand_word() >> $urandom_range(0, SUM_W - 1);
    endcase
  endfunction

  function automatic logic [31:0] rand_coord(input bit extremes_only);
    int pick;
    pick = extremes_only ? 0 : $urandom_range(0, 9);
    case (pick)
      0:       return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      1:       return '0;
      2, 3, 4: return $urandom();
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic body_t rand_body(input bit extremes_only);
    body_t b;
    b.target_x = rand_coord(extremes_only);
    b.target_y = rand_coord(extremes_only);
    b.pos_x    = rand_coord(extremes_only);
    b.pos_y    = rand_coord(extremes_only);
    b.vel_x    = rand_coord(extremes_only);
    b.vel_y    = rand_coord(extremes_only);
    // Now and then a body sits exactly on its goal.
    if (!extremes_only && $urandom_range(0, 15) == 0) begin
      b.pos_x = b.target_x;
      b.pos_y = b.target_y;
    end
    return b;
  endfunction

  function automatic body_t mk_body(input logic [31:0] tx, ty, px, py, vx, vy);
    body_t b;
    b.target_x = tx;
    b.target_y = ty;
    b.pos_x    = px;
    b.pos_y    = py;
    b.vel_x    = vx;
    b.vel_y    = vy;
    return b;
  endfunction

  function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] index,
                                          input logic [CFG_DATA_W-1:0] value);
    stim_row_t r;
    r = '0;
    r.kind      = ROW_WRITE;
    r.reg_index = index;
    r.reg_value = value;
    return r;
  endfunction

  function automatic stim_row_t body_row(input body_t b, input bit has_known,
                                         input logic [SUM_W-1:0] sum, input bit flag);
    stim_row_t r;
    r = '0;
    r.kind                  = ROW_BODY;
    r.body                  = b;
    r.has_known             = has_known;
    r.known.distance_sum    = sum;
    r.known.satisfied       = flag;
    return r;
  endfunction

  // Sum receiver: draws a stall before each transfer, raises m_tready, and
  // takes m_tdata on the falling edge before the edge that completes the
  // transfer.
  initial begin
    int                     stall;
    logic [OUT_TDATA_W-1:0] seen;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = out_rush ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (!m_tvalid);
      seen = m_tdata;
      @(posedge clk);
      score_sum(result_t'(seen[SUM_W:0]));
    end
  end

  // Stimulus: reset, the directed list, then random phases until enough
  // bodies have gone in, then the drain and the verdict.
  initial begin
    int                    span;
    int                    states;
    int                    n_items;
    int                    mid;
    int                    phase;
    bit                    extremes;
    logic [COUNT_W-1:0]    count_val;
    logic [CFG_DATA_W-1:0] noise;

    // Directed part. Sums are written out only where they are obvious: a
    // body at rest on its goal, one unit of offset, an only-end state too
    // short to count anything. The rest is scored by the model.
    add_row(body_row(mk_body(0, 0, 0, 0, 0, 0), 1'b1, '0, 1'b0));
    add_row(body_row(mk_body(Q_ONE, 0, 0, 0, 0, 0), 1'b1, 40'h1_0000, 1'b0));
    add_row(write_row(gda_pkg::REG_GOAL_THRESHOLD, 40'h1_0001));
    add_row(body_row(mk_body(Q_ONE, 0, 0, 0, 0, 0), 1'b1, 40'h1_0000, 1'b1));
    // Largest offsets, heading toward the goal from either side and then straight away from it.
    add_row(body_row(mk_body(Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX), 1'b0, '0, 1'b0));
    add_row(body_row(mk_body(Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN), 1'b0, '0, 1'b0));
    add_row(body_row(mk_body(Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b0, '0, 1'b0));
    // A moving body whose dot product cancels to exactly zero.
    add_row(body_row(mk_body(Q_ONE, Q_ONE, 0, 0, 32'h1, 32'hFFFF_FFFF), 1'b0, '0, 1'b0));
    add_row(body_row(mk_body(0, 32'hFFFF_0000, 0, 0, 0, 32'h0005_0000), 1'b0, '0, 1'b0));
    add_row(body_row(mk_body(Q_ONE, 32'hFFFF_0000, 0, 0, 32'h0002_0000,
                             32'h0001_0000), 1'b0, '0, 1'b0));
    add_row(write_row(REG_SPARE, SUM_MAX));
    add_row(write_row(gda_pkg::REG_BODY_COUNT, '0));
    add_row(body_row(mk_body(32'h0123_4567, 32'hFEDC_BA98, 32'h89AB_CDEF,
                             32'h7654_3210, 32'h0F0F_0F0F, 32'hF0F0_F0F0),
                     1'b0, '0, 1'b0));
    add_row(write_row(gda_pkg::REG_ONLY_END, 40'd1));
    add_row(write_row(gda_pkg::REG_BODY_COUNT, 40'd2));
    add_row(body_row(mk_body(Q_ONE, 0, 0, 0, 0, 0), 1'b0, '0, 1'b0));
    add_row(body_row(mk_body(Q_ONE, 0, 0, 0, 0, 0), 1'b1, '0, 1'b1));
    // Three bodies in only-end mode: the first counts. The threshold changes
    // while the state is half done and must not disturb it.
    add_row(write_row(gda_pkg::REG_BODY_COUNT, 40'd3));
    add_row(body_row(mk_body(Q_ONE, Q_ONE, 0, 0, 0, 0), 1'b0, '0, 1'b0));
    add_row(write_row(gda_pkg::REG_GOAL_THRESHOLD, SUM_MAX));
    add_row(body_row(mk_body(Q_MAX, Q_MAX, Q_MIN, Q_MIN, 0, 0), 1'b0, '0, 1'b0));
    add_row(body_row(mk_body(Q_MIN, 0, Q_MAX, 0, 0, 0), 1'b0, '0, 1'b0));
    add_row(write_row(gda_pkg::REG_ONLY_END, '0));
    add_row(write_row(gda_pkg::REG_GOAL_THRESHOLD, '0));
    add_row(write_row(gda_pkg::REG_BODY_COUNT, 40'd2));
    add_row(body_row(mk_body(Q_ONE, 0, 0, 0, Q_MIN, 0), 1'b0, '0, 1'b0));
    add_row(body_row(mk_body(0, Q_MAX, 0, 0, 0, Q_MAX), 1'b0, '0, 1'b0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_quiet();
        write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
      end else begin
        send_body(directed_rows[i].body, directed_rows[i].has_known, directed_rows[i].known);
      end
    end

    // Random phases. Each one waits for the core to drain, writes every
    // register (upper data bits random, so masking is exercised too), and
    // then sends whole states, sometimes with a trailing partial state that
    // the next body_count write throws away. The first phase is the heaviest
    // setting: an over-range count, extreme bodies, the largest threshold.
    phase = 0;
    while (bodies_sent < TARGET_BODIES) begin
      wait_quiet();
      count_val = (phase == 0) ? COUNT_W'(127) : pick_count();
      noise = rand_word();
      noise[COUNT_W-1:0] = count_val;
      write_reg(gda_pkg::REG_BODY_COUNT, noise);
      write_reg(gda_pkg::REG_ONLY_END, (phase == 0) ? '0 : rand_word());
      write_reg(gda_pkg::REG_GOAL_THRESHOLD, (phase == 0) ? SUM_MAX : pick_threshold());
      if ($urandom_range(0, 5) == 0) write_reg(REG_SPARE, rand_word());

      span     = effective_span(count_val);
      states   = (span >= MAX_BODIES) ? $urandom_range(1, 2) : $urandom_range(2, 8);
      n_items  = states * span;
      if ($urandom_range(0, 3) == 0) n_items += $urandom_range(0, span - 1);
      extremes = (phase == 0) || ($urandom_range(0, 7) == 0);
      in_rush  = ($urandom_range(0, 4) == 0);
      out_rush = ($urandom_range(0, 4) == 0);

      // Some phases get a register write in the middle, with a state still
      // open inside the core.
      mid = -1;
      if (n_items > 1 && $urandom_range(0, 3) == 0) mid = $urandom_range(1, n_items - 1);

      for (int k = 0; k < n_items; k++) begin
        if (k == mid) begin
          wait_quiet();
          case ($urandom_range(0, 3))
            0:       write_reg(gda_pkg::REG_BODY_COUNT,
                               (rand_word() << COUNT_W) | CFG_DATA_W'(pick_count()));
            1:       write_reg(gda_pkg::REG_ONLY_END, rand_word());
            2:       write_reg(gda_pkg::REG_GOAL_THRESHOLD, pick_threshold());
            default: write_reg(REG_SPARE, rand_word());
          endcase
        end
        send_body(rand_body(extremes), 1'b0, '0);
      end
      phase++;
    end

    in_rush  = 1'b0;
    out_rush = 1'b0;
    wait_quiet();

    $display("Covered %0d bodies and %0d register writes over %0d random phases.",
             bodies_sent, writes_done, phase);
    $display("%0d sums came back, %0d of them under the threshold; %0d mismatches.",
             sums_seen, sums_under, mismatches);
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
